// ===== hdl/tsa_pkg.sv =====
// Shared types and constants for the trilinear splat accumulator.
// Holds the queued command and result words and the back-end state encoding.
// No dependencies.
package tsa_pkg;

  localparam int POS_W = 16;
  localparam int AMT_W = 24;
  localparam int IDX_W = 18;
  localparam int VAL_W = 40;

  localparam logic [VAL_W-1:0] ACC_MAX = '1;

  localparam int GRID_DEF = 64;
  localparam int FRAC_DEF = 8;

  // Widest address and fraction over the legal parameter ranges
  localparam int ADDR_MAX_W = 24;
  localparam int FRAC_MAX_W = 16;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_DEPOSIT,
    OP_READ,
    OP_SKIP,
    OP_BLANK
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_READY,
    BK_SPLAT,
    BK_GAP
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic [AMT_W-1:0]      amount;
    logic [ADDR_MAX_W-1:0] base;
    logic [FRAC_MAX_W-1:0] fx;
    logic [FRAC_MAX_W-1:0] fy;
    logic [FRAC_MAX_W-1:0] fz;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] voxel_value;
    logic             skipped;
    logic             saturated;
  } res_t;

endpackage

// ===== hdl/tsa_channels.sv =====
// Valid/ready channel interfaces for the splat accumulator's item and result words.
// Depends on tsa_pkg for field widths.
interface tsa_in_if import tsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [AMT_W-1:0]        amount;
  logic [IDX_W-1:0]        voxel_index;

  modport source (output valid, kind, pos_x, pos_y, pos_z, amount, voxel_index,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, amount, voxel_index,
                output ready);
endinterface

interface tsa_out_if import tsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] voxel_value;
  logic             skipped;
  logic             saturated;

  modport source (output valid, voxel_value, skipped, saturated, input ready);
  modport sink (input valid, voxel_value, skipped, saturated, output ready);
endinterface

// ===== hdl/trilinear_splat_accumulator_unit.sv =====
// Top level of the trilinear splat accumulator: front end, command queue,
// back end with the volume RAM, and result queue.
// Depends on tsa_pkg, tsa_channels, tsa_fifo, tsa_front and tsa_back.

// After reset the block sweeps the whole volume to zero, one voxel a cycle,
// over all GRID*GRID*GRID voxels (262144 at the default GRID of 64); input
// ready stays low until the sweep is done. A deposit then runs as eight
// read-modify-write passes, one per corner, on the single write port of the
// volume RAM, plus a gap state so that the next item never reads a voxel
// whose update is still in the pipe. A read, a skipped deposit or an
// out-of-range read is issued as a single pass, but the back end starts an
// item only while fewer than two are waiting for their result word to be
// taken, so it can take a second item before the first is through. With idle
// queues the front end classifies in the accept cycle and the back end
// issues in the next cycle; three stages form the corner weight, the voxel is
// read at the end of the third and the add lands in the fourth, and the
// result queue presents the word in the cycle after. Accumulators saturate
// at 2^40-1 per voxel.
// Two-entry queues on both sides let the input keep flowing while a result
// waits to be taken.
module trilinear_splat_accumulator_unit import tsa_pkg::*; #(
  parameter int GRID      = GRID_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tsa_in_if.sink   in_ch,
  tsa_out_if.source out_ch
);
  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  logic             cmd_push;
  cmd_t             cmd;
  logic             cmd_full, cmd_empty, cmd_pop;
  logic [CMD_W-1:0] cmd_dout;
  cmd_t             q_head;
  logic             run;

  logic             res_push, res_pop, res_full, res_empty;
  res_t             res;
  logic [RES_W-1:0] res_dout;
  res_t             res_head;

  // Classify each accepted word into a deposit, read, skip or blank command
  tsa_front #(
    .GRID      (GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_ch    (in_ch),
    .q_full   (cmd_full),
    .run      (run),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  // Decouple the front end from the back end
  tsa_fifo #(
    .W     (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  assign q_head = cmd_t'(cmd_dout);

  // Carry out commands against the volume; hold off while results back up
  tsa_back #(
    .GRID      (GRID),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!cmd_empty),
    .q_head   (q_head),
    .q_pop    (cmd_pop),
    .res_push (res_push),
    .res      (res),
    .res_pop  (res_pop),
    .run      (run)
  );

  // Result queue; the back end only starts an item when a slot is reserved
  tsa_fifo #(
    .W     (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (res_pop),
    .dout  (res_dout),
    .full  (res_full),
    .empty (res_empty)
  );

  assign res_head           = res_t'(res_dout);
  assign out_ch.valid       = !res_empty;
  assign out_ch.voxel_value = res_head.voxel_value;
  assign out_ch.skipped     = res_head.skipped;
  assign out_ch.saturated   = res_head.saturated;
  assign res_pop            = out_ch.valid && out_ch.ready;

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!res_full || res_pop))
    else $error("result word pushed into a full result queue");

  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !run |-> !cmd_push)
    else $error("word accepted during the clearing sweep");
`endif
endmodule

// ===== hdl/tsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/tsa_fifo.sv =====
// Small synchronous FIFO used for the command and result queues.
// No dependencies.
module tsa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         full,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = CNT_W'(count_r + CNT_W'(push) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
endmodule

// ===== hdl/tsa_front.sv =====
// Front end: accepts item words and classifies them into queued commands.
// Depends on tsa_pkg and the channel interfaces in tsa_channels.
module tsa_front import tsa_pkg::*; #(
  parameter int GRID      = GRID_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  tsa_in_if.sink in_ch,
  input  logic   q_full,
  input  logic   run,
  output logic   cmd_push,
  output cmd_t   cmd
);
  localparam int VOXELS = GRID * GRID * GRID;
  localparam int ADDR_W = $clog2(VOXELS);
  localparam int AX_W   = $clog2(GRID);
  localparam int IDX_CW = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
  localparam logic [VAL_W-1:0] LIMIT = VAL_W'(GRID - 1) << FRAC_BITS;

  logic            out_x, out_y, out_z;
  logic [AX_W-1:0] ix, iy, iz;
  logic [ADDR_W-1:0] base;
  logic            idx_ok;

  // Outside the interior: negative, or at or past the last full cell
  function automatic logic axis_out(input logic signed [POS_W-1:0] p);
    return p[POS_W-1] || (VAL_W'(unsigned'(p)) >= LIMIT);
  endfunction

  function automatic logic [AX_W-1:0] axis_int(input logic signed [POS_W-1:0] p);
    return AX_W'(unsigned'(p) >> FRAC_BITS);
  endfunction

  assign in_ch.ready = run && !q_full;
  assign cmd_push    = in_ch.valid && in_ch.ready;

  always_comb begin
    out_x  = axis_out(in_ch.pos_x);
    out_y  = axis_out(in_ch.pos_y);
    out_z  = axis_out(in_ch.pos_z);
    ix     = axis_int(in_ch.pos_x);
    iy     = axis_int(in_ch.pos_y);
    iz     = axis_int(in_ch.pos_z);
    base   = ADDR_W'(ADDR_W'(ix) * ADDR_W'(GRID * GRID) + ADDR_W'(iy) * ADDR_W'(GRID)
                     + ADDR_W'(iz));
    idx_ok = IDX_CW'(in_ch.voxel_index) < IDX_CW'(VOXELS);

    cmd.amount = in_ch.amount;
    cmd.fx     = FRAC_MAX_W'(in_ch.pos_x[FRAC_BITS-1:0]);
    cmd.fy     = FRAC_MAX_W'(in_ch.pos_y[FRAC_BITS-1:0]);
    cmd.fz     = FRAC_MAX_W'(in_ch.pos_z[FRAC_BITS-1:0]);
    if (in_ch.kind) begin
      cmd.op   = idx_ok ? OP_READ : OP_BLANK;
      cmd.base = ADDR_MAX_W'(in_ch.voxel_index);
    end else begin
      cmd.op   = (out_x || out_y || out_z) ? OP_SKIP : OP_DEPOSIT;
      cmd.base = ADDR_MAX_W'(base);
    end
  end
endmodule

// ===== hdl/tsa_back.sv =====
// Back end: clears the volume after reset, then runs commands through the
// weight multiplier pipeline and the read-modify-write path of the volume RAM.
// Depends on tsa_pkg and tsa_ram.
module tsa_back import tsa_pkg::*; #(
  parameter int GRID      = GRID_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_head,
  output logic q_pop,
  output logic res_push,
  output res_t res,
  input  logic res_pop,
  output logic run
);
  localparam int VOXELS = GRID * GRID * GRID;
  localparam int ADDR_W = $clog2(VOXELS);
  localparam int W_W    = FRAC_BITS + 1;
  localparam int P1_W   = AMT_W + W_W;
  localparam int P2_W   = P1_W + W_W;
  localparam int SPL    = P2_W / 2;
  localparam int HI_W   = P2_W - SPL;
  localparam int P3_W   = P2_W + W_W;
  localparam int PEND_W = $clog2(OUTQ_DEPTH + 1);
  localparam logic [ADDR_W-1:0] CLR_LAST    = ADDR_W'(VOXELS - 1);
  localparam logic [2:0]        CORNER_LAST = 3'd7;
  localparam logic [W_W-1:0]    ONE_W       = W_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic vld;
    logic last;
    op_t  op;
  } pass_t;

  back_state_t       state_r, state_nxt;
  logic [2:0]        corner_r, corner_nxt;
  logic [2:0]        corner;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              sat_acc_r, sat_acc_nxt;
  logic              start, issue;

  logic [W_W-1:0]    fx, fy, fz, wx, wy, wz;
  logic [ADDR_W-1:0] offset;

  pass_t             s1_pass_r, s1_pass_nxt;
  logic [ADDR_W-1:0] s1_addr_r, s1_addr_nxt;
  logic [P1_W-1:0]   s1_p1_r, s1_p1_nxt;
  logic [W_W-1:0]    s1_wy_r, s1_wz_r;

  pass_t             s2_pass_r;
  logic [ADDR_W-1:0] s2_addr_r;
  logic [P2_W-1:0]   s2_p2_r, s2_p2_nxt;
  logic [W_W-1:0]    s2_wz_r;

  pass_t                s3_pass_r;
  logic [ADDR_W-1:0]    s3_addr_r;
  logic [HI_W+W_W-1:0]  s3_pa_r, s3_pa_nxt;
  logic [SPL+W_W-1:0]   s3_pb_r, s3_pb_nxt;

  pass_t             s4_pass_r;
  logic [ADDR_W-1:0] s4_addr_r;
  logic [AMT_W-1:0]  s4_share_r, s4_share_nxt;
  logic [P3_W-1:0]   prod;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;
  logic [VAL_W:0]    sum;
  logic              sat_now;
  logic              s4_dep;

  // Issue sequencer: one pass per cycle, eight per deposit, a gap state after; a new item waits for a result slot
  always_comb begin
    state_nxt    = state_r;
    corner_nxt   = corner_r;
    clr_addr_nxt = clr_addr_r;
    start        = 1'b0;
    issue        = 1'b0;
    corner       = '0;
    q_pop        = 1'b0;
    case (state_r)
      BK_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = BK_READY;
        end
      end
      BK_READY: begin
        if (q_valid && (pend_r < PEND_W'(OUTQ_DEPTH))) begin
          start = 1'b1;
          issue = 1'b1;
          if (q_head.op == OP_DEPOSIT) begin
            corner_nxt = 3'd1;
            state_nxt  = BK_SPLAT;
          end else begin
            q_pop = 1'b1;
          end
        end
      end
      BK_SPLAT: begin
        issue      = 1'b1;
        corner     = corner_r;
        corner_nxt = corner_r + 1'b1;
        if (corner_r == CORNER_LAST) begin
          q_pop     = 1'b1;
          state_nxt = BK_GAP;
        end
      end
      BK_GAP: begin
        state_nxt = BK_READY;
      end
      default: begin
        state_nxt = BK_CLEAR;
      end
    endcase
  end

  assign run = (state_r != BK_CLEAR);

  always_comb begin
    fx     = W_W'(q_head.fx[FRAC_BITS-1:0]);
    fy     = W_W'(q_head.fy[FRAC_BITS-1:0]);
    fz     = W_W'(q_head.fz[FRAC_BITS-1:0]);
    wx     = corner[2] ? fx : ONE_W - fx;
    wy     = corner[1] ? fy : ONE_W - fy;
    wz     = corner[0] ? fz : ONE_W - fz;
    offset = (corner[2] ? ADDR_W'(GRID * GRID) : '0)
           + (corner[1] ? ADDR_W'(GRID) : '0)
           + ADDR_W'(corner[0]);

    s1_pass_nxt.vld  = issue;
    s1_pass_nxt.last = q_pop;
    s1_pass_nxt.op   = q_head.op;
    s1_addr_nxt      = q_head.base[ADDR_W-1:0] + offset;
    s1_p1_nxt        = P1_W'(q_head.amount) * P1_W'(wx);
    s2_p2_nxt        = P2_W'(s1_p1_r) * P2_W'(s1_wy_r);
    s3_pa_nxt        = (HI_W + W_W)'(s2_p2_r[P2_W-1:SPL]) * (HI_W + W_W)'(s2_wz_r);
    s3_pb_nxt        = (SPL + W_W)'(s2_p2_r[SPL-1:0]) * (SPL + W_W)'(s2_wz_r);
    prod             = (P3_W'(s3_pa_r) << SPL) + P3_W'(s3_pb_r);
    s4_share_nxt     = AMT_W'(prod >> (3 * FRAC_BITS));
  end

  // Volume access: read in stage three, add and write back in stage four
  assign ram_re = s3_pass_r.vld && ((s3_pass_r.op == OP_DEPOSIT) || (s3_pass_r.op == OP_READ));
  assign s4_dep = s4_pass_r.vld && (s4_pass_r.op == OP_DEPOSIT);

  always_comb begin
    sum       = {1'b0, ram_rdata} + (VAL_W + 1)'(s4_share_r);
    sat_now   = sum[VAL_W];
    ram_we    = (state_r == BK_CLEAR) || s4_dep;
    ram_waddr = (state_r == BK_CLEAR) ? clr_addr_r : s4_addr_r;
    ram_wdata = (state_r == BK_CLEAR) ? '0 : (sat_now ? ACC_MAX : sum[VAL_W-1:0]);

    res_push        = s4_pass_r.vld && s4_pass_r.last;
    res.voxel_value = (s4_pass_r.op == OP_READ) ? ram_rdata : '0;
    res.skipped     = (s4_pass_r.op == OP_SKIP);
    res.saturated   = (s4_pass_r.op == OP_DEPOSIT) && (sat_acc_r || sat_now);

    sat_acc_nxt = sat_acc_r;
    if (s4_pass_r.vld) begin
      sat_acc_nxt = s4_pass_r.last ? 1'b0 : (sat_acc_r || (s4_dep && sat_now));
    end

    pend_nxt = PEND_W'(pend_r + PEND_W'(start) - PEND_W'(res_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      corner_r   <= '0;
      clr_addr_r <= '0;
      pend_r     <= '0;
      sat_acc_r  <= 1'b0;
      s1_pass_r  <= '0;
      s2_pass_r  <= '0;
      s3_pass_r  <= '0;
      s4_pass_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      corner_r   <= corner_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
      sat_acc_r  <= sat_acc_nxt;
      s1_pass_r  <= s1_pass_nxt;
      s2_pass_r  <= s1_pass_r;
      s3_pass_r  <= s2_pass_r;
      s4_pass_r  <= s3_pass_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= s1_addr_nxt;
    s1_p1_r    <= s1_p1_nxt;
    s1_wy_r    <= wy;
    s1_wz_r    <= wz;
    s2_addr_r  <= s1_addr_r;
    s2_p2_r    <= s2_p2_nxt;
    s2_wz_r    <= s1_wz_r;
    s3_addr_r  <= s2_addr_r;
    s3_pa_r    <= s3_pa_nxt;
    s3_pb_r    <= s3_pb_nxt;
    s4_addr_r  <= s3_addr_r;
    s4_share_r <= s4_share_nxt;
  end

  tsa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VOXELS)
  ) u_volume (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (s3_addr_r),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && ram_we) |-> (s3_addr_r != ram_waddr))
    else $error("volume read and write hit the same voxel in one cycle");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PEND_W'(OUTQ_DEPTH))
    else $error("more items pending than result slots");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !(s1_pass_r.vld || s2_pass_r.vld || s3_pass_r.vld
                                || s4_pass_r.vld))
    else $error("pass in flight during the clearing sweep");

  a_gap_after_splat: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_head.op == OP_DEPOSIT)) |=> !issue)
    else $error("no gap cycle after the last corner of a deposit");

  a_result_owned: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (pend_r != '0))
    else $error("result produced with no item pending");
`endif
endmodule

// ===== tb/trilinear_splat_accumulator_unit_test.sv =====
// Self-checking bench for the trilinear splat accumulator: a directed table, a run piled
// onto one voxel and random traffic, scored against a shadow volume kept here or a fixed answer.
// Depends on tsa_pkg, tsa_channels and the trilinear_splat_accumulator_unit RTL.
module trilinear_splat_accumulator_unit_test;
  import tsa_pkg::*;

  localparam int GRID     = GRID_DEF;
  localparam int FRAC     = FRAC_DEF;
  localparam int ONE_W    = 1 << FRAC;
  // First coordinate (in fixed point) that lies outside the interior
  localparam int LIMIT    = (GRID - 1) << FRAC;
  localparam int IDLE_PCT = 32;
  localparam int N_RANDOM = 860;
  // Full-amount deposits stacked onto one voxel without idling
  localparam int PILE_RUN = 16;
  localparam int MAX_SHOWN = 20;

  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct {
    logic                    kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [AMT_W-1:0]        amount;
    logic [IDX_W-1:0]        voxel_index;
  } splat_item_t;

  // One row of the directed table; a fixed answer is given only where it is obvious
  typedef struct {
    splat_item_t item;
    int          reps;
    bit          fixed;
    res_t        answer;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tsa_in_if  in_ch ();
  tsa_out_if out_ch ();

  trilinear_splat_accumulator_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Shadow of the voxel volume: absent entries are still zero from the reset sweep
  logic [VAL_W-1:0] shadow_volume [int];
  res_t             awaited_results [$];
  int               touched_voxels [$];
  table_row_t       directed_rows [$];
  int               hot_spot [4][3];
  bit               calm = 1'b0;

  int n_checked = 0;
  int n_mismatch = 0;
  int n_deposits = 0;
  int n_skipped = 0;
  int n_clipped = 0;
  int n_reads = 0;

  function automatic int voxel_of(int x, int y, int z);
    return x * GRID * GRID + y * GRID + z;
  endfunction

  function automatic logic [VAL_W-1:0] stored_value(int vox);
    return shadow_volume.exists(vox) ? shadow_volume[vox] : '0;
  endfunction

  function automatic void note_touched(int vox);
    touched_voxels.push_back(vox);
    if (touched_voxels.size() > 64) void'(touched_voxels.pop_front());
  endfunction

  // Apply one word to the shadow volume and return the result the block owes for it
  function automatic res_t accumulate_item(splat_item_t it);
    res_t             r;
    int               p [3];
    int               ip [3];
    logic [63:0]      fw [3];
    logic [63:0]      cw [3];
    logic [63:0]      share;
    logic [VAL_W:0]   sum;
    int               base;
    int               vox;
    r = '0;
    if (it.kind == KIND_READ) begin
      // An 18-bit index always falls inside the 64^3 volume
      r.voxel_value = stored_value(int'(it.voxel_index));
      return r;
    end
    p[0] = it.pos_x;
    p[1] = it.pos_y;
    p[2] = it.pos_z;
    for (int k = 0; k < 3; k++) begin
      if (p[k] < 0 || p[k] >= LIMIT) begin
        r.skipped = 1'b1;
        return r;
      end
      ip[k] = p[k] >> FRAC;
      fw[k] = 64'(p[k] & (ONE_W - 1));
      cw[k] = 64'(ONE_W) - fw[k];
    end
    base = voxel_of(ip[0], ip[1], ip[2]);
    for (int dx = 0; dx < 2; dx++) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dz = 0; dz < 2; dz++) begin
          share = (64'(it.amount) * (dx ? fw[0] : cw[0]) * (dy ? fw[1] : cw[1])
                   * (dz ? fw[2] : cw[2])) >> (3 * FRAC);
          vox = base + voxel_of(dx, dy, dz);
          sum = {1'b0, stored_value(vox)} + share[VAL_W:0];
          if (sum > {1'b0, ACC_MAX}) begin
            shadow_volume[vox] = ACC_MAX;
            r.saturated = 1'b1;
          end else begin
            shadow_volume[vox] = sum[VAL_W-1:0];
          end
          note_touched(vox);
        end
      end
    end
    return r;
  endfunction

  function automatic splat_item_t make_item(logic kind, int x, int y, int z, int amount,
                                            int index);
    splat_item_t it;
    it.kind        = kind;
    it.pos_x       = POS_W'(x);
    it.pos_y       = POS_W'(y);
    it.pos_z       = POS_W'(z);
    it.amount      = AMT_W'(amount);
    it.voxel_index = IDX_W'(index);
    return it;
  endfunction

  function automatic void add_row(splat_item_t it, int reps, bit fixed,
                                  logic [VAL_W-1:0] value, logic skip, logic sat);
    table_row_t row;
    row.item   = it;
    row.reps   = reps;
    row.fixed  = fixed;
    row.answer = '{voxel_value: value, skipped: skip, saturated: sat};
    directed_rows.push_back(row);
  endfunction

  function automatic splat_item_t random_item();
    splat_item_t it;
    int          sel;
    int          h;
    int          c [3];
    logic [POS_W-1:0] bad;
    // Start from pure noise so the fields a word ignores still toggle
    it.kind        = KIND_DEPOSIT;
    it.pos_x       = POS_W'($urandom);
    it.pos_y       = POS_W'($urandom);
    it.pos_z       = POS_W'($urandom);
    it.amount      = AMT_W'($urandom);
    it.voxel_index = IDX_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      // Interior deposit, mostly clustered round a hot spot so voxels pile up
      h = $urandom_range(0, 3);
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 3) == 0) c[k] = $urandom_range(0, LIMIT - 1);
        else c[k] = hot_spot[h][k] + $urandom_range(0, 767) - 384;
        if (c[k] < 0) c[k] = 0;
        if (c[k] > LIMIT - 1) c[k] = LIMIT - 1;
      end
      it.pos_x = POS_W'(c[0]);
      it.pos_y = POS_W'(c[1]);
      it.pos_z = POS_W'(c[2]);
      case ($urandom_range(0, 9))
        0: it.amount = '1;
        1: it.amount = AMT_W'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (sel < 60) begin
      // Force one axis out of the interior: negative or at or past the last full cell
      if ($urandom_range(0, 1)) bad = POS_W'($urandom_range(32768, 65535));
      else bad = POS_W'($urandom_range(LIMIT, 32767));
      case ($urandom_range(0, 2))
        0: it.pos_x = bad;
        1: it.pos_y = bad;
        default: it.pos_z = bad;
      endcase
    end else begin
      it.kind = KIND_READ;
      if (touched_voxels.size() > 0 && $urandom_range(0, 99) < 70)
        it.voxel_index = IDX_W'(touched_voxels[$urandom_range(0, touched_voxels.size() - 1)]);
    end
    return it;
  endfunction

  // Offer one word from a falling edge; hold valid high after acceptance so a
  // following word goes out without a gap unless an idle cycle is drawn
  task automatic send_item(splat_item_t it, bit fixed, res_t answer);
    res_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.kind        = it.kind;
    in_ch.pos_x       = it.pos_x;
    in_ch.pos_y       = it.pos_y;
    in_ch.pos_z       = it.pos_z;
    in_ch.amount      = it.amount;
    in_ch.voxel_index = it.voxel_index;
    do @(posedge clk); while (!in_ch.ready);
    predicted = accumulate_item(it);
    awaited_results.push_back(fixed ? answer : predicted);
    if (it.kind == KIND_READ) n_reads++;
    else n_deposits++;
    if (predicted.skipped) n_skipped++;
    if (predicted.saturated) n_clipped++;
    @(negedge clk);
  endtask

  task automatic flag_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    n_mismatch++;
    if (n_mismatch <= MAX_SHOWN)
      $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // Result side: draw ready at the falling edge, score words at the rising edge
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_ch.voxel_value);
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        if (out_ch.voxel_value !== want.voxel_value)
          flag_mismatch("voxel_value", want.voxel_value, out_ch.voxel_value);
        if (out_ch.skipped !== want.skipped)
          flag_mismatch("skipped", want.skipped, out_ch.skipped);
        if (out_ch.saturated !== want.saturated)
          flag_mismatch("saturated", want.saturated, out_ch.saturated);
      end
    end
  end

  // Watchdog: the reset sweep, the directed table and the random part fit well inside
  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    splat_item_t it;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_DEPOSIT;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.pos_z       = '0;
    in_ch.amount      = '0;
    in_ch.voxel_index = '0;

    // Reads of a fresh volume, including the far corner with noisy unused fields
    add_row(make_item(KIND_READ, 0, 0, 0, 0, 0), 1, 1, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, -1, -1, -1, 'hFFFFFF, voxel_of(63, 63, 63)), 1, 1,
            '0, 1'b0, 1'b0);
    // Positions outside the interior: negative, lowest, at the limit, highest
    add_row(make_item(KIND_DEPOSIT, -1, 0, 0, 'hFFFFFF, 0), 1, 1, '0, 1'b1, 1'b0);
    add_row(make_item(KIND_DEPOSIT, 0, -32768, 0, 'hFFFFFF, 0), 1, 1, '0, 1'b1, 1'b0);
    add_row(make_item(KIND_DEPOSIT, 0, 0, LIMIT, 'hFFFFFF, 0), 1, 1, '0, 1'b1, 1'b0);
    add_row(make_item(KIND_DEPOSIT, 32767, 32767, 32767, 'hFFFFFF, 0), 1, 1,
            '0, 1'b1, 1'b0);
    // Whole-voxel position: the full amount lands on one corner
    add_row(make_item(KIND_DEPOSIT, 0, 0, 0, 'hFFFFFF, 'h3FFFF), 1, 1, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(0, 0, 0)), 1, 1,
            40'hFF_FFFF, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(0, 0, 1)), 1, 1, '0, 1'b0, 1'b0);
    // Last interior position, spilling into the far corner of the volume
    add_row(make_item(KIND_DEPOSIT, LIMIT - 1, LIMIT - 1, LIMIT - 1, 'hFFFFFF, 0), 1, 0,
            '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(62, 62, 62)), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(63, 63, 63)), 1, 0, '0, 1'b0, 1'b0);
    // Cell centre: eight equal shares
    add_row(make_item(KIND_DEPOSIT, 'h80, 'h80, 'h80, 'h010000, 0), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(1, 1, 1)), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(0, 0, 0)), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_DEPOSIT, 'h5A3, 'h1FF, 'h2C1, 0, 0), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_DEPOSIT, 'h3E7E, 'h0001, 'h00FF, 'h123456, 0), 1, 0,
            '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(62, 0, 0)), 1, 0, '0, 1'b0, 1'b0);
    // Stack full-amount deposits onto one voxel back to back
    add_row(make_item(KIND_DEPOSIT, 10 << FRAC, 10 << FRAC, 10 << FRAC, 'hFFFFFF, 0),
            PILE_RUN, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(10, 10, 10)), 1, 0,
            '0, 1'b0, 1'b0);
    add_row(make_item(KIND_DEPOSIT, (10 << FRAC) | 'h80, 10 << FRAC, 10 << FRAC, 'hFFFFFF,
                      0), 1, 0, '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(10, 10, 10)), 1, 0,
            '0, 1'b0, 1'b0);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, voxel_of(11, 10, 10)), 1, 0, '0, 1'b0, 1'b0);

    // Hold reset, then wait out the clearing sweep through the ready handshake
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      // Long runs go without any idling on either side
      calm = (directed_rows[r].reps > 1);
      repeat (directed_rows[r].reps)
        send_item(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].answer);
    end
    calm = 1'b0;

    for (int h = 0; h < 4; h++)
      for (int k = 0; k < 3; k++) hot_spot[h][k] = $urandom_range(384, LIMIT - 385);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 400 && n < 520);
      it = random_item();
      send_item(it, 1'b0, '0);
    end
    calm = 1'b0;
    in_ch.valid = 1'b0;

    // Drain, then give the pipe time to show any stray word
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Scored %0d results: %0d deposits (%0d outside the interior, %0d clipping)",
             n_checked, n_deposits, n_skipped, n_clipped);
    $display("and %0d reads, with a %0d-deposit pile onto one voxel.",
             n_reads, PILE_RUN);
    if (n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tsa_pkg.sv
hdl/tsa_channels.sv
hdl/tsa_ram.sv
hdl/tsa_fifo.sv
hdl/tsa_front.sv
hdl/tsa_back.sv
hdl/trilinear_splat_accumulator_unit.sv
tb/trilinear_splat_accumulator_unit_test.sv
